>>> rtl/vmeu_pkg.sv
// ============================================================================
// vmeu_pkg: shared definitions of the variable machine execute unit
// Widths, command and fault codes, controller states, item structs and the
// jump condition test on the compare flag.
// ============================================================================
package vmeu_pkg;

	localparam int DATA_W     = 32;
	localparam int CMD_W      = 4;
	localparam int SLOT_W     = 6;
	localparam int TGT_W      = 10;
	localparam int FAULT_W    = 2;
	localparam int SLOTS      = 64;
	localparam int SLOT_IDX_W = $clog2(SLOTS);
	localparam int PROG_SLOTS = 1024;

	typedef enum logic [CMD_W-1:0] {
		CMD_DEC = 4'd0,
		CMD_MOV = 4'd1,
		CMD_OUT = 4'd2,
		CMD_ADD = 4'd3,
		CMD_SUB = 4'd4,
		CMD_MUL = 4'd5,
		CMD_DIV = 4'd6,
		CMD_MOD = 4'd7,
		CMD_CMP = 4'd8,
		CMD_JE  = 4'd9,
		CMD_JNE = 4'd10,
		CMD_JL  = 4'd11,
		CMD_JLE = 4'd12,
		CMD_JG  = 4'd13,
		CMD_JGE = 4'd14,
		CMD_JMP = 4'd15
	} cmd_t;

	typedef enum logic [FAULT_W-1:0] {
		FLT_OK     = 2'd0,
		FLT_UNDECL = 2'd1,
		FLT_DIVZ   = 2'd2,
		FLT_HALTED = 2'd3
	} fault_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_DIV,
		ST_FINISH
	} state_t;

	typedef struct packed {
		cmd_t                     command;
		logic [SLOT_W-1:0]        first_slot;
		logic                     first_is_literal;
		logic signed [DATA_W-1:0] first_literal;
		logic [SLOT_W-1:0]        second_slot;
		logic                     second_is_literal;
		logic signed [DATA_W-1:0] second_literal;
		logic [TGT_W-1:0]         jump_target;
	} instr_t;

	typedef struct packed {
		logic                     print_valid;
		logic signed [DATA_W-1:0] print_value;
		logic                     branch_taken;
		logic [TGT_W-1:0]         next_position;
		fault_t                   fault;
	} res_t;

	function automatic logic flag_test(cmd_t cmd, logic [DATA_W-1:0] flag);
		logic zero;
		logic neg;
		logic hit;
		zero = (flag == '0);
		neg  = flag[DATA_W-1];
		case (cmd)
			CMD_JE:  hit = zero;
			CMD_JNE: hit = !zero;
			CMD_JL:  hit = neg;
			CMD_JLE: hit = neg || zero;
			CMD_JG:  hit = !neg && !zero;
			CMD_JGE: hit = !neg;
			default: hit = 1'b1;
		endcase
		return hit;
	endfunction

endpackage

>>> rtl/vmeu_if.sv
// ============================================================================
// vmeu_if: channel interfaces of the variable machine execute unit
// One interface for the instruction channel and one for the result channel,
// each with valid/ready and a source and a sink modport.
// ============================================================================
interface vmeu_in_if;
	import vmeu_pkg::*;

	logic                     valid;
	logic                     ready;
	logic [CMD_W-1:0]         command;
	logic [SLOT_W-1:0]        first_slot;
	logic                     first_is_literal;
	logic signed [DATA_W-1:0] first_literal;
	logic [SLOT_W-1:0]        second_slot;
	logic                     second_is_literal;
	logic signed [DATA_W-1:0] second_literal;
	logic [TGT_W-1:0]         jump_target;

	modport source (
		output valid, command, first_slot, first_is_literal, first_literal,
		       second_slot, second_is_literal, second_literal, jump_target,
		input  ready
	);
	modport sink (
		input  valid, command, first_slot, first_is_literal, first_literal,
		       second_slot, second_is_literal, second_literal, jump_target,
		output ready
	);
endinterface

interface vmeu_out_if;
	import vmeu_pkg::*;

	logic                     valid;
	logic                     ready;
	logic                     print_valid;
	logic signed [DATA_W-1:0] print_value;
	logic                     branch_taken;
	logic [TGT_W-1:0]         next_position;
	logic [FAULT_W-1:0]       fault;

	modport source (
		output valid, print_valid, print_value, branch_taken, next_position, fault,
		input  ready
	);
	modport sink (
		input  valid, print_valid, print_value, branch_taken, next_position, fault,
		output ready
	);
endinterface

>>> rtl/vmeu_ram.sv
// ============================================================================
// vmeu_ram: generic synchronous RAM
// One write port and two read ports, read data registered.
// ============================================================================
module vmeu_ram #(
	parameter int  DEPTH = 64,
	parameter int  WIDTH = 32,
	localparam int AW    = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr_a,
	output logic [WIDTH-1:0] rdata_a,
	input  logic [AW-1:0]    raddr_b,
	output logic [WIDTH-1:0] rdata_b
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_a <= mem[raddr_a];
		rdata_b <= mem[raddr_b];
	end
endmodule

>>> rtl/vmeu_divider.sv
// ============================================================================
// vmeu_divider: iterative signed divider
// Restoring division on magnitudes, one quotient bit per cycle; the quotient
// truncates toward zero and the remainder takes the sign of the dividend.
// ============================================================================
module vmeu_divider (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [vmeu_pkg::DATA_W-1:0]  dividend,
	input  logic [vmeu_pkg::DATA_W-1:0]  divisor,
	output logic                         done,
	output logic [vmeu_pkg::DATA_W-1:0]  quotient,
	output logic [vmeu_pkg::DATA_W-1:0]  remainder
);
	import vmeu_pkg::*;

	localparam int CNT_W = $clog2(DATA_W);

	logic              busy_q;
	logic              done_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [DATA_W-1:0] rem_q;
	logic [DATA_W-1:0] quo_q;
	logic [DATA_W-1:0] den_q;
	logic              qneg_q;
	logic              rneg_q;

	logic [DATA_W:0]   shifted;
	logic [DATA_W:0]   diff;
	logic              qbit;

	assign shifted = {rem_q, quo_q[DATA_W-1]};
	assign diff    = shifted - {1'b0, den_q};
	assign qbit    = !diff[DATA_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(DATA_W - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= '0;
			quo_q  <= dividend[DATA_W-1] ? (~dividend + 1'b1) : dividend;
			den_q  <= divisor[DATA_W-1] ? (~divisor + 1'b1) : divisor;
			qneg_q <= dividend[DATA_W-1] ^ divisor[DATA_W-1];
			rneg_q <= dividend[DATA_W-1];
		end else if (busy_q) begin
			rem_q <= qbit ? diff[DATA_W-1:0] : shifted[DATA_W-1:0];
			quo_q <= {quo_q[DATA_W-2:0], qbit};
		end
	end

	assign done      = done_q;
	assign quotient  = qneg_q ? (~quo_q + 1'b1) : quo_q;
	assign remainder = rneg_q ? (~rem_q + 1'b1) : rem_q;
endmodule

>>> rtl/variable_machine_execute_unit.sv
// ============================================================================
// variable_machine_execute_unit: execute stage of a small variable machine
// Runs one decoded instruction per transfer against a RAM of signed 32-bit
// variables with declared marks, a compare flag and a sticky halted bit.
// ============================================================================
// Sequence: after the instruction transfer the controller passes through the
// execute and finish states, and the result is registered as it leaves finish,
// which waits while the output register still holds an untaken result; DIV and
// MOD also wait in the divide state for the bit-serial divider. One instruction
// at a time; the divider's one quotient bit per cycle sets the worst case.
// Reset clears the declared marks, the compare flag, the halted bit and the
// controller at once; slot values are not cleared and need no clearing pass.
module variable_machine_execute_unit (
	input  logic clk,
	input  logic arst_n,
	vmeu_in_if.sink    instr,
	vmeu_out_if.source result
);
	import vmeu_pkg::*;

	// Controller state and the latched instruction. The instruction stays in
	// ins_q for the whole execution, so the slot RAM is read once at the
	// transfer and written once at the finish: accesses never overlap.
	state_t            state_q;
	state_t            state_d;
	instr_t            ins_q;

	// Architectural state besides the slot values.
	logic [SLOTS-1:0]  decl_q;
	logic [DATA_W-1:0] flag_q;
	logic              halted_q;

	// Pending result and side effects, settled in the execute state; the DIV/MOD write data when the divider finishes.
	res_t              pend_q;
	logic [DATA_W-1:0] wdata_q;
	logic              wr_en_q;
	logic              decl_set_q;
	logic              flag_wr_q;

	// Output register.
	res_t              out_q;
	logic              out_valid_q;

	// Controller outputs and the divider's completion pulse.
	logic              accept;
	logic              go_div;
	logic              load_out;
	logic              div_done;

	// Slot RAM ports.
	logic [DATA_W-1:0] rd_a;
	logic [DATA_W-1:0] rd_b;

	// Execute-cycle datapath.
	logic [SLOT_IDX_W-1:0] idx1;
	logic [SLOT_IDX_W-1:0] idx2;
	logic              slot1_ok;
	logic              slot2_ok;
	logic              lit1_used;
	logic [DATA_W-1:0] opa;
	logic [DATA_W-1:0] opb;
	logic              a_ok;
	logic              b_ok;
	logic [DATA_W-1:0] product;
	logic [DATA_W-1:0] div_q;
	logic [DATA_W-1:0] div_r;
	res_t              exe_res;
	logic [DATA_W-1:0] exe_wdata;
	logic              exe_wr;
	logic              exe_decl;
	logic              exe_flag;
	logic              exe_div;

	// ------------------------------------------------------------------
	// Slot value RAM. Reads are addressed straight from the channel so the
	// operands arrive in the execute cycle; the write-back happens when the
	// result is loaded into the output register.
	// ------------------------------------------------------------------
	vmeu_ram #(
		.DEPTH (SLOTS),
		.WIDTH (DATA_W)
	) u_slot_ram (
		.clk     (clk),
		.we      (load_out && wr_en_q),
		.waddr   (ins_q.first_slot[SLOT_IDX_W-1:0]),
		.wdata   (wdata_q),
		.raddr_a (instr.first_slot[SLOT_IDX_W-1:0]),
		.rdata_a (rd_a),
		.raddr_b (instr.second_slot[SLOT_IDX_W-1:0]),
		.rdata_b (rd_b)
	);

	vmeu_divider u_divider (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (go_div),
		.dividend  (opa),
		.divisor   (opb),
		.done      (div_done),
		.quotient  (div_q),
		.remainder (div_r)
	);

	// ------------------------------------------------------------------
	// Controller: next state.
	// ------------------------------------------------------------------
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (instr.valid) begin
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				state_d = exe_div ? ST_DIV : ST_FINISH;
			end
			ST_DIV: begin
				if (div_done) begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (!out_valid_q || result.ready) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// ------------------------------------------------------------------
	// Controller: outputs. The finish cycle waits only for the output
	// register to be free, so a new instruction is taken while the previous
	// result still waits for its transfer.
	// ------------------------------------------------------------------
	always_comb begin
		instr.ready = (state_q == ST_IDLE);
		go_div      = (state_q == ST_EXEC) && exe_div;
		load_out    = (state_q == ST_FINISH) && (!out_valid_q || result.ready);
	end

	assign accept = instr.valid && instr.ready;

	// ------------------------------------------------------------------
	// Operand selection and checks. A slot counts as usable only when it is
	// inside the file and declared. The first literal is honored by OUT and
	// CMP alone; DEC, MOV, ADD, SUB, MUL, DIV and MOD use first_slot as the destination.
	// ------------------------------------------------------------------
	assign idx1      = ins_q.first_slot[SLOT_IDX_W-1:0];
	assign idx2      = ins_q.second_slot[SLOT_IDX_W-1:0];
	assign slot1_ok  = (32'(ins_q.first_slot) < SLOTS) && decl_q[idx1];
	assign slot2_ok  = (32'(ins_q.second_slot) < SLOTS) && decl_q[idx2];
	assign lit1_used = ins_q.first_is_literal &&
		((ins_q.command == CMD_OUT) || (ins_q.command == CMD_CMP));
	assign opa       = lit1_used ? ins_q.first_literal : rd_a;
	assign opb       = ins_q.second_is_literal ? ins_q.second_literal : rd_b;
	assign a_ok      = lit1_used || slot1_ok;
	assign b_ok      = ins_q.second_is_literal || slot2_ok;
	assign product   = opa * opb;

	// Execute: decide the fault, the result fields and the side effects.
	always_comb begin
		exe_res   = '0;
		exe_wdata = '0;
		exe_wr    = 1'b0;
		exe_decl  = 1'b0;
		exe_flag  = 1'b0;
		exe_div   = 1'b0;
		if (halted_q) begin
			exe_res.fault = FLT_HALTED;
		end else begin
			case (ins_q.command)
				CMD_DEC: begin
					// Redeclaration keeps the value; out of range does nothing.
					if ((32'(ins_q.first_slot) < SLOTS) && !decl_q[idx1]) begin
						exe_wr   = 1'b1;
						exe_decl = 1'b1;
					end
				end
				CMD_OUT: begin
					if (!a_ok) begin
						exe_res.fault = FLT_UNDECL;
					end else begin
						exe_res.print_valid = 1'b1;
						exe_res.print_value = opa;
					end
				end
				CMD_CMP: begin
					if (!a_ok || !b_ok) begin
						exe_res.fault = FLT_UNDECL;
					end else begin
						exe_flag  = 1'b1;
						exe_wdata = opa - opb;
					end
				end
				CMD_JE, CMD_JNE, CMD_JL, CMD_JLE, CMD_JG, CMD_JGE, CMD_JMP: begin
					if (flag_test(ins_q.command, flag_q)) begin
						exe_res.branch_taken  = 1'b1;
						exe_res.next_position = (32'(ins_q.jump_target) >= PROG_SLOTS) ?
							TGT_W'(PROG_SLOTS - 1) : ins_q.jump_target;
					end
				end
				default: begin
					// MOV, ADD, SUB, MUL, DIV and MOD: destination checked first,
					// then the source, then the divisor.
					if (!slot1_ok || !b_ok) begin
						exe_res.fault = FLT_UNDECL;
					end else if (((ins_q.command == CMD_DIV) ||
						(ins_q.command == CMD_MOD)) && (opb == '0)) begin
						exe_res.fault = FLT_DIVZ;
					end else begin
						exe_wr = 1'b1;
						case (ins_q.command)
							CMD_MOV: exe_wdata = opb;
							CMD_ADD: exe_wdata = opa + opb;
							CMD_SUB: exe_wdata = opa - opb;
							CMD_MUL: exe_wdata = product;
							default: exe_div   = 1'b1;
						endcase
					end
				end
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Control registers.
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			decl_q      <= '0;
			flag_q      <= '0;
			halted_q    <= 1'b0;
			out_valid_q <= 1'b0;
			wr_en_q     <= 1'b0;
			decl_set_q  <= 1'b0;
			flag_wr_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_EXEC) begin
				wr_en_q    <= exe_wr;
				decl_set_q <= exe_decl;
				flag_wr_q  <= exe_flag;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
				if (decl_set_q) begin
					decl_q[idx1] <= 1'b1;
				end
				if (flag_wr_q) begin
					flag_q <= wdata_q;
				end
				if ((pend_q.fault == FLT_UNDECL) || (pend_q.fault == FLT_DIVZ)) begin
					halted_q <= 1'b1;
				end
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// ------------------------------------------------------------------
	// Payload registers.
	// ------------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (accept) begin
			ins_q <= '{
				command:           cmd_t'(instr.command),
				first_slot:        instr.first_slot,
				first_is_literal:  instr.first_is_literal,
				first_literal:     instr.first_literal,
				second_slot:       instr.second_slot,
				second_is_literal: instr.second_is_literal,
				second_literal:    instr.second_literal,
				jump_target:       instr.jump_target
			};
		end
		if (state_q == ST_EXEC) begin
			pend_q  <= exe_res;
			wdata_q <= exe_wdata;
		end
		if ((state_q == ST_DIV) && div_done) begin
			wdata_q <= (ins_q.command == CMD_DIV) ? div_q : div_r;
		end
		if (load_out) begin
			out_q <= pend_q;
		end
	end

	assign result.valid         = out_valid_q;
	assign result.print_valid   = out_q.print_valid;
	assign result.print_value   = out_q.print_value;
	assign result.branch_taken  = out_q.branch_taken;
	assign result.next_position = out_q.next_position;
	assign result.fault         = out_q.fault;

	// ------------------------------------------------------------------
	// Assertions.
	// ------------------------------------------------------------------
	a_halt_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		halted_q |=> halted_q)
		else $error("halted bit cleared without reset");

	a_halted_result: assert property (@(posedge clk) disable iff (!arst_n)
		(load_out && halted_q) |-> (pend_q.fault == FLT_HALTED))
		else $error("instruction executed while halted");

	a_div_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == ST_DIV))
		else $error("divider finished outside the divide wait");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !result.ready) |-> !load_out)
		else $error("pending result overwritten");

	a_fault_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		(load_out && (pend_q.fault != FLT_OK)) |-> (!wr_en_q && !flag_wr_q))
		else $error("faulting instruction changed state");
endmodule
